// ===== src/skad_pkg.sv =====
// Shared types and constants for the keypoint argmax decoder.
// Used by skad_tracker, skad_result and simcc_keypoint_argmax_decode_top.
// No dependencies.
package skad_pkg;

   localparam int VALUE_W          = 16;
   localparam int RATIO_W          = 9;
   localparam int LOC_W            = 19;
   localparam int LOC_MAX          = 262143;
   localparam int MAX_BINS_DEFAULT = 1024;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [LOC_W-1:0]   loc_type;
   typedef logic        [RATIO_W-1:0] ratio_type;

   localparam ratio_type RATIO_RESET   = ratio_type'(256);
   localparam loc_type   LOC_NOT_FOUND = loc_type'(-256);

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_INV_SPLIT_RATIO = 1'b0;

   // Row codes of axis_select.
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

endpackage

// ===== src/skad_tracker.sv =====
// Per-axis running maximum and first-argmax trackers with a keypoint snapshot
// register that holds both rows' results once both rows have ended.
// Depends on skad_pkg.
module skad_tracker #(
   parameter int MAX_BINS = skad_pkg::MAX_BINS_DEFAULT,
   localparam int IDX_W   = $clog2(MAX_BINS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  skad_pkg::value_type item_value,
   input  logic                item_axis,
   input  logic                item_eor,
   output logic                kp_valid,
   input  logic                kp_ready,
   output skad_pkg::value_type kp_x_value,
   output logic [IDX_W-1:0]    kp_x_index,
   output skad_pkg::value_type kp_y_value,
   output logic [IDX_W-1:0]    kp_y_index
);

   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(MAX_BINS - 1);

   skad_pkg::value_type best_value_ff [0:1];
   skad_pkg::value_type best_value_in [0:1];
   logic [IDX_W-1:0]    best_index_ff [0:1];
   logic [IDX_W-1:0]    best_index_in [0:1];
   logic [IDX_W-1:0]    count_ff      [0:1];
   logic [IDX_W-1:0]    count_in      [0:1];
   logic                done_ff       [0:1];
   logic                done_in       [0:1];
   logic                hit           [0:1];

   skad_pkg::value_type kp_x_value_ff;
   logic [IDX_W-1:0]    kp_x_index_ff;
   skad_pkg::value_type kp_y_value_ff;
   logic [IDX_W-1:0]    kp_y_index_ff;
   logic                kp_valid_ff;
   logic                kp_valid_in;

   logic                other_done;
   logic                closes;
   logic                fire;
   logic                finish;

   // Lane update: what each axis tracker becomes if this bin lands on it.
   for (genvar a = 0; a < 2; a++) begin : g_lane
      logic take;
      assign hit[a]  = (item_axis == 1'(a)) && !done_ff[a];
      assign take    = (count_ff[a] == '0) || (item_value > best_value_ff[a]);
      assign best_value_in[a] = (hit[a] && take) ? item_value  : best_value_ff[a];
      assign best_index_in[a] = (hit[a] && take) ? count_ff[a] : best_index_ff[a];
      assign count_in[a] = (hit[a] && count_ff[a] != LAST_BIN) ?
                           count_ff[a] + IDX_W'(1) : count_ff[a];
      assign done_in[a]  = done_ff[a] || (hit[a] && item_eor);
   end

   assign other_done = (item_axis == skad_pkg::AXIS_X) ? done_ff[1] : done_ff[0];
   // This bin ends its row while the other row is already finished.
   assign closes = item_valid && item_eor && other_done &&
                   ((item_axis == skad_pkg::AXIS_X) ? hit[0] : hit[1]);

   assign item_ready  = !closes || kp_ready;
   assign fire        = item_valid && item_ready;
   assign finish      = fire && closes;
   assign kp_valid_in = finish || (kp_valid_ff && !kp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            best_value_ff[a] <= '0;
            best_index_ff[a] <= '0;
            count_ff[a]      <= '0;
            done_ff[a]       <= 1'b0;
         end
      end else if (finish) begin
         for (int a = 0; a < 2; a++) begin
            best_value_ff[a] <= '0;
            best_index_ff[a] <= '0;
            count_ff[a]      <= '0;
            done_ff[a]       <= 1'b0;
         end
      end else if (fire) begin
         for (int a = 0; a < 2; a++) begin
            best_value_ff[a] <= best_value_in[a];
            best_index_ff[a] <= best_index_in[a];
            count_ff[a]      <= count_in[a];
            done_ff[a]       <= done_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_valid_ff <= 1'b0;
      end else begin
         kp_valid_ff <= kp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         kp_x_value_ff <= best_value_in[0];
         kp_x_index_ff <= best_index_in[0];
         kp_y_value_ff <= best_value_in[1];
         kp_y_index_ff <= best_index_in[1];
      end
   end

   assign kp_valid   = kp_valid_ff;
   assign kp_x_value = kp_x_value_ff;
   assign kp_x_index = kp_x_index_ff;
   assign kp_y_value = kp_y_value_ff;
   assign kp_y_index = kp_y_index_ff;

endmodule

// ===== src/skad_result.sv =====
// Result stage: score as the smaller row maximum, scaled and saturated
// locations, and the result output register.
// Depends on skad_pkg.
module skad_result #(
   parameter int MAX_BINS = skad_pkg::MAX_BINS_DEFAULT,
   localparam int IDX_W   = $clog2(MAX_BINS)
) (
   input  logic                clock,
   input  logic                reset,
   input  skad_pkg::ratio_type inv_split_ratio,
   input  logic                kp_valid,
   output logic                kp_ready,
   input  skad_pkg::value_type kp_x_value,
   input  logic [IDX_W-1:0]    kp_x_index,
   input  skad_pkg::value_type kp_y_value,
   input  logic [IDX_W-1:0]    kp_y_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output skad_pkg::loc_type   rsp_x_location,
   output skad_pkg::loc_type   rsp_y_location,
   output skad_pkg::value_type rsp_keypoint_score,
   output logic                rsp_found
);

   localparam int PROD_W = IDX_W + skad_pkg::RATIO_W;
   localparam int SAT_W  = skad_pkg::LOC_W - 1;

   skad_pkg::value_type score;
   logic                found;
   logic [PROD_W-1:0]   x_prod;
   logic [PROD_W-1:0]   y_prod;
   logic [31:0]         x_wide;
   logic [31:0]         y_wide;
   logic [SAT_W-1:0]    x_sat;
   logic [SAT_W-1:0]    y_sat;
   logic                load;

   skad_pkg::loc_type   x_location_ff;
   skad_pkg::loc_type   x_location_in;
   skad_pkg::loc_type   y_location_ff;
   skad_pkg::loc_type   y_location_in;
   skad_pkg::value_type score_ff;
   logic                found_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   assign score  = (kp_x_value > kp_y_value) ? kp_y_value : kp_x_value;
   assign found  = score > 0;
   assign x_prod = PROD_W'(kp_x_index) * PROD_W'(inv_split_ratio);
   assign y_prod = PROD_W'(kp_y_index) * PROD_W'(inv_split_ratio);
   assign x_wide = 32'(x_prod);
   assign y_wide = 32'(y_prod);
   assign x_sat  = (x_wide > 32'(skad_pkg::LOC_MAX)) ? SAT_W'(skad_pkg::LOC_MAX) :
                   x_wide[SAT_W-1:0];
   assign y_sat  = (y_wide > 32'(skad_pkg::LOC_MAX)) ? SAT_W'(skad_pkg::LOC_MAX) :
                   y_wide[SAT_W-1:0];

   assign x_location_in = found ? {1'b0, x_sat} : skad_pkg::LOC_NOT_FOUND;
   assign y_location_in = found ? {1'b0, y_sat} : skad_pkg::LOC_NOT_FOUND;

   assign kp_ready     = !rsp_valid_ff || rsp_ready;
   assign load         = kp_valid && kp_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_location_ff <= x_location_in;
         y_location_ff <= y_location_in;
         score_ff      <= score;
         found_ff      <= found;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_x_location     = x_location_ff;
   assign rsp_y_location     = y_location_ff;
   assign rsp_keypoint_score = score_ff;
   assign rsp_found          = found_ff;

endmodule

// ===== src/simcc_keypoint_argmax_decode_top.sv =====
// Keypoint argmax decoder top level: input register, ratio register, trackers, result stage.
// A result passes from the input register through the tracker's keypoint register to the result register.
// Throughput: one bin word per cycle, unless a row end waits for the result stage to take the keypoint.
// Reset (synchronous, active high) clears trackers, valids and sets ratio to 1.0.
// Depends on skad_pkg, skad_tracker and skad_result.
module simcc_keypoint_argmax_decode_top #(
   parameter int MAX_BINS = skad_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  skad_pkg::value_type                 req_bin_value,
   input  logic                                req_axis_select,
   input  logic                                req_end_of_row,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output skad_pkg::loc_type                   rsp_x_location,
   output skad_pkg::loc_type                   rsp_y_location,
   output skad_pkg::value_type                 rsp_keypoint_score,
   output logic                                rsp_found,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [skad_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [skad_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [skad_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDX_W = $clog2(MAX_BINS);

   skad_pkg::ratio_type ratio_ff;
   logic                reg_sel;
   logic                csr_write;

   logic                in_valid_ff;
   logic                in_valid_in;
   skad_pkg::value_type in_value_ff;
   logic                in_axis_ff;
   logic                in_eor_ff;
   logic                item_ready;

   logic                kp_valid;
   logic                kp_ready;
   skad_pkg::value_type kp_x_value;
   logic [IDX_W-1:0]    kp_x_index;
   skad_pkg::value_type kp_y_value;
   logic [IDX_W-1:0]    kp_y_index;

   // Configuration port.
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2] == skad_pkg::REG_INV_SPLIT_RATIO;
   assign csr_write = psel && penable && pwrite && pready && reg_sel;
   assign prdata    = reg_sel ? skad_pkg::CSR_DATA_W'(ratio_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= skad_pkg::RATIO_RESET;
      end else if (csr_write) begin
         ratio_ff <= pwdata[skad_pkg::RATIO_W-1:0];
      end
   end

   // Input register; it refills in the same cycle that the tracker takes its word.
   assign req_ready   = !in_valid_ff || item_ready;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_value_ff <= req_bin_value;
         in_axis_ff  <= req_axis_select;
         in_eor_ff   <= req_end_of_row;
      end
   end

   skad_tracker #(
      .MAX_BINS (MAX_BINS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_ready (item_ready),
      .item_value (in_value_ff),
      .item_axis  (in_axis_ff),
      .item_eor   (in_eor_ff),
      .kp_valid   (kp_valid),
      .kp_ready   (kp_ready),
      .kp_x_value (kp_x_value),
      .kp_x_index (kp_x_index),
      .kp_y_value (kp_y_value),
      .kp_y_index (kp_y_index)
   );

   skad_result #(
      .MAX_BINS (MAX_BINS)
   ) u_result (
      .clock              (clock),
      .reset              (reset),
      .inv_split_ratio    (ratio_ff),
      .kp_valid           (kp_valid),
      .kp_ready           (kp_ready),
      .kp_x_value         (kp_x_value),
      .kp_x_index         (kp_x_index),
      .kp_y_value         (kp_y_value),
      .kp_y_index         (kp_y_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_x_location     (rsp_x_location),
      .rsp_y_location     (rsp_y_location),
      .rsp_keypoint_score (rsp_keypoint_score),
      .rsp_found          (rsp_found)
   );

`ifndef SYNTHESIS
   // A miss reports both locations as minus 256.
   a_miss_locations: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_x_location == skad_pkg::LOC_NOT_FOUND &&
         rsp_y_location == skad_pkg::LOC_NOT_FOUND)
      else $error("miss result carries a location");

   // A hit never carries a negative location or a non-positive score.
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         !rsp_x_location[skad_pkg::LOC_W-1] && !rsp_y_location[skad_pkg::LOC_W-1] &&
         rsp_keypoint_score > 0)
      else $error("hit result out of range");

   // An empty input register always takes a new word.
   a_input_free: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled while empty");
`endif

endmodule
